FILE: rtl/rrfna_pkg.sv
// Shared types and constants for the round-robin free-node allocator.
`default_nettype none

package rrfna_pkg;

  // Width of the node number, grant, count and node-count register fields.
  localparam int unsigned NODE_W = 7;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;

  // Default number of nodes the hardware can track.
  localparam int unsigned MAX_NODES_DEF = 64;
  // Reset value of the node-count register.
  localparam int unsigned NODES_RESET = 64;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLAIM   = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE_FREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [NODE_W-1:0] node_number;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] granted_node;
    logic [ST_W-1:0]   status;
    logic [NODE_W-1:0] free_nodes;
    logic              all_idle;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/round_robin_free_node_allocator.sv
// Pipeline: a request is registered in the input stage, and its result is registered in the
// result stage, where rsp_valid_o strobes it.
// Throughput: one request per cycle; busy is never raised, the round-robin search is
// a single rotating priority encoder over the busy map between two registers.
// Reset: all nodes free, last grant pointer zero, node count 64 (clamped to MAX_NODES).
// A node-count write reinitializes the same state. The receiver cannot stall results.
`default_nettype none

module round_robin_free_node_allocator #(
  parameter int unsigned MAX_NODES = rrfna_pkg::MAX_NODES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rrfna_pkg::cmd_t               cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rrfna_pkg::NODE_W-1:0]  cfg_wdata_i,
  output logic                               rsp_valid_o,
  output rrfna_pkg::rsp_t                    rsp_o
);

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned TW = (CW > rrfna_pkg::NODE_W) ? CW : rrfna_pkg::NODE_W;
  localparam int unsigned RstTotal =
    (rrfna_pkg::NODES_RESET > MAX_NODES) ? MAX_NODES : rrfna_pkg::NODES_RESET;

  // Input stage.
  logic            cmd_vld_q;
  rrfna_pkg::cmd_t cmd_q;

  // Allocator state.
  logic [MAX_NODES-1:0] busy_map_q, busy_map_d;
  logic [IW-1:0]        last_q, last_d;
  logic [CW-1:0]        free_q, free_d;
  logic [CW-1:0]        total_q;

  // Result stage.
  logic            rsp_vld_q;
  rrfna_pkg::rsp_t rsp_q, rsp_d;

  // Datapath signals.
  logic [TW-1:0]        total_tw;
  logic [TW-1:0]        cfg_tw;
  logic [TW-1:0]        cfg_total;
  logic [MAX_NODES-1:0] tracked;
  logic [IW-1:0]        search_start;
  logic                 found;
  logic [IW-1:0]        found_idx;
  logic [TW-1:0]        num_tw;
  logic                 range_bad;
  logic [IW-1:0]        sel_idx;
  logic                 sel_busy;
  logic [IW-1:0]        grant_idx;
  logic                 granted;

  assign busy = 1'b0;

  assign total_tw = TW'(total_q);
  assign cfg_tw   = TW'(cfg_wdata_i);

  // A written count of zero acts as one; counts past the hardware size saturate.
  always_comb begin
    if (cfg_tw == '0) begin
      cfg_total = TW'(1);
    end else if (cfg_tw > TW'(MAX_NODES)) begin
      cfg_total = TW'(MAX_NODES);
    end else begin
      cfg_total = cfg_tw;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      tracked[i] = TW'(i) < total_tw;
    end
  end

  // The search starts one past the last grant and wraps at the node count.
  assign search_start = ((TW'(last_q) + TW'(1)) == total_tw) ? '0 : IW'(TW'(last_q) + TW'(1));

  rrfna_search #(
    .MAX_NODES (MAX_NODES),
    .IW        (IW)
  ) u_search (
    .free_i  (~busy_map_q & tracked),
    .start_i (search_start),
    .found_o (found),
    .idx_o   (found_idx)
  );

  assign num_tw    = TW'(cmd_q.node_number);
  assign range_bad = (num_tw == '0) || (num_tw > total_tw);
  assign sel_idx   = IW'(num_tw - TW'(1));
  assign sel_busy  = busy_map_q[sel_idx];

  always_comb begin
    busy_map_d = busy_map_q;
    last_d     = last_q;
    free_d     = free_q;
    granted    = 1'b0;
    grant_idx  = found_idx;
    rsp_d      = '0;
    rsp_d.status = rrfna_pkg::ST_OK;
    unique case (cmd_q.opcode)
      rrfna_pkg::OP_ALLOC: begin
        if (found && (free_q != '0)) begin
          granted               = 1'b1;
          busy_map_d[grant_idx] = 1'b1;
          last_d                = grant_idx;
          free_d                = free_q - CW'(1);
        end else begin
          rsp_d.status = rrfna_pkg::ST_NONE_FREE;
        end
      end
      rrfna_pkg::OP_RELEASE: begin
        if (range_bad) begin
          rsp_d.status = rrfna_pkg::ST_RANGE;
        end else if (sel_busy) begin
          busy_map_d[sel_idx] = 1'b0;
          free_d              = free_q + CW'(1);
        end
      end
      rrfna_pkg::OP_CLAIM: begin
        if (range_bad) begin
          rsp_d.status = rrfna_pkg::ST_RANGE;
        end else if (!sel_busy) begin
          busy_map_d[sel_idx] = 1'b1;
          free_d              = free_q - CW'(1);
        end
      end
      default: begin
        // The unused opcode only reports the current counts.
      end
    endcase
    rsp_d.granted_node = granted ? rrfna_pkg::NODE_W'(TW'(grant_idx) + TW'(1)) : '0;
    rsp_d.free_nodes   = rrfna_pkg::NODE_W'(TW'(free_d));
    rsp_d.all_idle     = (free_d == total_q);
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q  <= 1'b0;
      rsp_vld_q  <= 1'b0;
      busy_map_q <= '0;
      last_q     <= '0;
      free_q     <= CW'(RstTotal);
      total_q    <= CW'(RstTotal);
    end else begin
      cmd_vld_q <= start;
      rsp_vld_q <= cmd_vld_q;
      if (cfg_we_i) begin
        busy_map_q <= '0;
        last_q     <= '0;
        free_q     <= CW'(cfg_total);
        total_q    <= CW'(cfg_total);
      end else if (cmd_vld_q) begin
        busy_map_q <= busy_map_d;
        last_q     <= last_d;
        free_q     <= free_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= cmd_i;
    end
    if (cmd_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/rrfna_search.sv
// Rotating priority encoder: first free node at or after a start index, with wrap.
`default_nettype none

module rrfna_search #(
  parameter int unsigned MAX_NODES = rrfna_pkg::MAX_NODES_DEF,
  parameter int unsigned IW        = $clog2(MAX_NODES)
) (
  input  wire logic [MAX_NODES-1:0] free_i,   // free and tracked nodes
  input  wire logic [IW-1:0]        start_i,
  output logic                      found_o,
  output logic [IW-1:0]             idx_o
);

  logic [MAX_NODES-1:0] upper;
  logic [MAX_NODES-1:0] cand;
  logic [MAX_NODES-1:0] first;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      upper[i] = free_i[i] && (IW'(i) >= start_i);
    end
    // Prefer nodes at or past the start; otherwise wrap to the lowest free node.
    cand  = (|upper) ? upper : free_i;
    first = cand & (~cand + MAX_NODES'(1));
    idx_o = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (first[i]) begin
        idx_o = idx_o | IW'(i);
      end
    end
  end

  assign found_o = |free_i;

endmodule

`default_nettype wire
